/* hw/rtl/rlam_pkg.sv */
`timescale 1ns / 1ps

package rlam_pkg;

   // shared multiplier operand and product widths
   localparam int MW = 33;
   localparam int PW = 2 * MW;

   // lfo values, q1.22 signed, with headroom
   localparam int LW = 25;
   localparam longint ONE_Q22 = 64'sd4194304;

   // quarter-wave cosine table
   localparam int COS_LOG = 8;
   localparam int COS_N = 1 << COS_LOG;
   localparam int CW = 23;
   localparam longint HALF_PI_Q30 = 64'sd1686629713;
   localparam longint Q30_ONE = 64'sd1073741824;
   localparam longint COS_DIV [1:10] = '{64'sd2, 64'sd12, 64'sd30, 64'sd56, 64'sd90,
                                         64'sd132, 64'sd182, 64'sd240, 64'sd306, 64'sd380};

   // smoothing and noise constants
   localparam logic [MW-1:0] AM_SMOOTH_COEF = 33'd655;
   localparam logic [MW-1:0] NOISE_INT_COEF = 33'd1311;
   localparam logic [MW-1:0] RECIP_1000_S27 = 33'd134218;
   localparam logic [MW-1:0] RECIP_1000_S36 = 33'd68719477;
   localparam logic [16:0] WET_FULL = 17'd65536;
   localparam logic [16:0] BYPASS_LIMIT = 17'd656;

   // lfo shapes
   localparam logic [1:0] SHAPE_SAW = 2'd0;
   localparam logic [1:0] SHAPE_SQUARE = 2'd1;
   localparam logic [1:0] SHAPE_TRIANGLE = 2'd2;
   localparam logic [1:0] SHAPE_NOISE = 2'd3;

   // register indexes
   localparam logic [2:0] CSR_WAVE_SHAPE = 3'd0;
   localparam logic [2:0] CSR_PHASE_STEP = 3'd1;
   localparam logic [2:0] CSR_AM_DEPTH = 3'd2;
   localparam logic [2:0] CSR_PM_SWING = 3'd3;
   localparam logic [2:0] CSR_BASE_DELAY = 3'd4;
   localparam logic [2:0] CSR_WET_MIX = 3'd5;

   localparam logic [19:0] BASE_DELAY_RESET = 20'd614400;

   // one cosine point in q1.22 unsigned, taylor series evaluated at elaboration
   function automatic logic [CW-1:0] cos_point(input int idx);
      longint x;
      longint x2;
      longint t;
      x = HALF_PI_Q30 * longint'(idx) / COS_N;
      x2 = x * x / Q30_ONE;
      t = Q30_ONE;
      for (int k = 10; k >= 1; k--) begin
         t = Q30_ONE - (t * x2 / Q30_ONE) / COS_DIV[k];
      end
      t = (t + 128) / 256;
      if (t < 0) t = 0;
      if (t > ONE_Q22) t = ONE_Q22;
      return CW'(t);
   endfunction

endpackage

/* hw/rtl/rlam_stream_if.sv */
`timescale 1ns / 1ps

// input channel: one stereo frame per word
interface rlam_req_if #(parameter int W = 24);
   logic valid;
   logic ready;
   logic signed [W-1:0] left_in;
   logic signed [W-1:0] right_in;
   modport source(output valid, output left_in, output right_in, input ready);
   modport sink(input valid, input left_in, input right_in, output ready);
endinterface

// result channel: one processed frame per word
interface rlam_rsp_if #(parameter int W = 24);
   logic valid;
   logic ready;
   logic signed [W-1:0] left_out;
   logic signed [W-1:0] right_out;
   modport source(output valid, output left_out, output right_out, input ready);
   modport sink(input valid, input left_out, input right_out, output ready);
endinterface

/* hw/rtl/retro_lfo_am_pm_modulator.sv */
`timescale 1ns / 1ps
// a low-mix word goes from the write state straight to the output state, others run the
// full sequence, whose length varies with the read-pointer wrap steps and the noise update
// on wraps; frames are taken one at a time, a new word only once the last result is handed
// on, with the single shared multiplier that the sequencer steps through every product of the frame
// reset: synchronous, active high; the delay store reads as zero until written, tracked
// by a fill count, so no clearing pass is needed and the block is ready straight away
module retro_lfo_am_pm_modulator #(
   parameter int DELAY_DEPTH = 8192,
   parameter int SAMPLE_BITS = 24
) (
   input  logic        clock,
   input  logic        reset,
   rlam_req_if.sink    req_port,
   rlam_rsp_if.source  rsp_port,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int AW = $clog2(DELAY_DEPTH);
   localparam int FW = AW + 1;
   localparam int SW = SAMPLE_BITS;
   localparam int MW = rlam_pkg::MW;
   localparam int PW = rlam_pkg::PW;
   localparam int LW = rlam_pkg::LW;
   localparam int CL = rlam_pkg::COS_LOG;
   localparam int RPW = ((AW + 8 > 22) ? AW + 8 : 22) + 2;
   localparam logic signed [RPW-1:0] MODM = RPW'(DELAY_DEPTH * 256);
   localparam logic [AW-1:0] LAST_IDX = AW'(DELAY_DEPTH - 1);
   localparam logic [FW-1:0] FULL_FILL = FW'(DELAY_DEPTH);
   localparam logic signed [LW-1:0] ONE_L = LW'(rlam_pkg::ONE_Q22);
   localparam logic signed [PW-1:0] ONE_P = PW'(rlam_pkg::ONE_Q22);
   localparam logic signed [PW-1:0] SMAX = {{(PW-SW+1){1'b0}}, {(SW-1){1'b1}}};
   localparam logic signed [PW-1:0] SMIN = ~SMAX;

   typedef enum logic [4:0] {
      S_IDLE, S_WRITE, S_SHAPE, S_PMV, S_AMS, S_NORM, S_GAIN, S_DLY,
      S_NQ, S_NM, S_NL, S_WRAP, S_RDA, S_RDB, S_LATB,
      S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7, S_OUT
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [1:0]  shape_ff, shape_in;
   logic [31:0] step_ff, step_in;
   logic [15:0] depth_ff, depth_in;
   logic [19:0] swing_ff, swing_in;
   logic [19:0] base_ff, base_in;
   logic [16:0] wet_ff, wet_in;

   // persistent state
   logic [AW-1:0] wi_ff, wi_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [31:0] phase_ff, phase_in;
   logic signed [LW-1:0] ams_ff, ams_in;
   logic signed [LW-1:0] nint_ff, nint_in;
   logic [16:0] nsh_ff, nsh_in;
   logic signed [15:0] nlev_ff, nlev_in;

   // per-frame working registers
   logic signed [SW-1:0] dry_l_ff, dry_l_in, dry_r_ff, dry_r_in;
   logic [16:0] wgt_ff, wgt_in;
   logic signed [LW-1:0] amv_ff, amv_in, pmv_ff, pmv_in;
   logic [22:0] gain_ff, gain_in;
   logic wrap_ff, wrap_in;
   logic signed [RPW-1:0] rp_ff, rp_in;
   logic [25:0] nval_ff, nval_in;
   logic rd_ok_ff, rd_ok_in;
   logic [2*SW-1:0] mem_a_ff, mem_a_in, mem_b_ff, mem_b_in;
   logic signed [PW-1:0] acc_ff, acc_in;
   logic signed [MW-1:0] wetv_ff, wetv_in;
   logic ch_ff, ch_in;
   logic signed [SW-1:0] res_l_ff, res_l_in, res_r_ff, res_r_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [SW-1:0] rsp_l_ff, rsp_l_in, rsp_r_ff, rsp_r_in;

   // shared multiplier
   logic signed [MW-1:0] mul_a, mul_b;
   logic signed [PW-1:0] prod;

   // memory ports
   logic          ram_we;
   logic [AW-1:0] ram_raddr;
   logic [2*SW-1:0] ram_q;

   // lfo helpers
   logic signed [32:0] saw_d;
   logic [31:0]   saw_ad;
   logic [30:0]   cos_u;
   logic [29:0]   cos_frac;
   logic [CL:0]   cos_idx;
   logic [rlam_pkg::CW-1:0] cos_base;
   logic signed [rlam_pkg::CW:0] cos_slope;
   logic signed [LW-1:0] noise_amv;
   logic [32:0]   phase_sum;

   // read pointer and mix helpers
   logic [AW-1:0] a_idx, b_idx;
   logic [7:0]    frac8;
   logic signed [SW-1:0] samp_a, samp_b, dry_ch;
   logic signed [PW-1:0] sum_w, mix_w, gain_w;
   logic signed [SW-1:0] mix_sat;
   logic [7:0]    nq;
   logic [9:0]    nm;
   logic          rsp_take;
   logic          req_take;

   assign req_take = req_port.valid && req_port.ready;
   assign rsp_take = !rsp_valid_ff || rsp_port.ready;

   // saw: distance from mid phase
   assign saw_d = $signed({1'b0, phase_ff}) - 33'sh0_8000_0000;
   assign saw_ad = saw_d[32] ? 32'(-saw_d) : saw_d[31:0];

   // triangle: fold phase into a quarter wave for the cosine table
   assign cos_u = phase_ff[30] ? (31'h4000_0000 - {1'b0, phase_ff[29:0]})
                               : {1'b0, phase_ff[29:0]};
   assign cos_idx = cos_u[30 -: CL + 1];
   assign cos_frac = {cos_u[29-CL:0], {CL{1'b0}}};

   assign noise_amv = LW'(nlev_ff) <<< 7;
   assign phase_sum = {1'b0, phase_ff} + {1'b0, step_ff};

   assign a_idx = rp_ff[8 +: AW];
   assign b_idx = (a_idx == LAST_IDX) ? '0 : a_idx + 1'b1;
   assign frac8 = rp_ff[7:0];

   assign samp_a = ch_ff ? mem_a_ff[2*SW-1:SW] : mem_a_ff[SW-1:0];
   assign samp_b = ch_ff ? mem_b_ff[2*SW-1:SW] : mem_b_ff[SW-1:0];
   assign dry_ch = ch_ff ? dry_r_ff : dry_l_ff;

   assign sum_w = acc_ff + prod;
   assign mix_w = sum_w >>> 16;
   assign mix_sat = (mix_w > SMAX) ? SMAX[SW-1:0] :
                    (mix_w < SMIN) ? SMIN[SW-1:0] : mix_w[SW-1:0];
   assign gain_w = ONE_P - (prod >>> 16);

   // noise level: remainder by 1000 through a reciprocal
   assign nq = prod[34:27];
   assign nm = 10'(nsh_ff - 17'(nq) * 17'd1000);

   rlam_cos_lut u_cos (
      .idx   (cos_idx),
      .base  (cos_base),
      .slope (cos_slope)
   );

   rlam_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   rlam_ram #(
      .WIDTH (2 * SW),
      .DEPTH (DELAY_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wi_ff),
      .wr_data ({dry_r_ff, dry_l_ff}),
      .rd_addr (ram_raddr),
      .rd_data (ram_q)
   );

   // multiplier operand selection
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_SHAPE: begin
            unique case (shape_ff)
               rlam_pkg::SHAPE_SAW: begin
                  mul_a = MW'(saw_ad);
                  mul_b = MW'(saw_ad);
               end
               rlam_pkg::SHAPE_TRIANGLE: begin
                  mul_a = MW'(cos_slope);
                  mul_b = MW'(cos_frac);
               end
               rlam_pkg::SHAPE_NOISE: begin
                  mul_a = MW'(noise_amv - nint_ff);
                  mul_b = rlam_pkg::NOISE_INT_COEF;
               end
               default: begin
                  mul_a = '0;
               end
            endcase
         end
         S_PMV: begin
            mul_a = MW'(amv_ff - ams_ff);
            mul_b = rlam_pkg::AM_SMOOTH_COEF;
         end
         S_NORM: begin
            mul_a = MW'((ams_ff + ONE_L) >>> 1);
            mul_b = MW'(depth_ff);
         end
         S_GAIN: begin
            mul_a = MW'(pmv_ff);
            mul_b = MW'(swing_ff);
         end
         S_DLY: begin
            mul_a = MW'(nsh_ff);
            mul_b = rlam_pkg::RECIP_1000_S27;
         end
         S_NM: begin
            mul_a = MW'(nval_ff);
            mul_b = rlam_pkg::RECIP_1000_S36;
         end
         S_M1: begin
            mul_a = MW'(samp_a);
            mul_b = MW'(9'd256 - {1'b0, frac8});
         end
         S_M2: begin
            mul_a = MW'(samp_b);
            mul_b = MW'(frac8);
         end
         S_M4: begin
            mul_a = wetv_ff;
            mul_b = MW'(gain_ff);
         end
         S_M5: begin
            mul_a = MW'(dry_ch);
            mul_b = MW'(rlam_pkg::WET_FULL - wgt_ff);
         end
         S_M6: begin
            mul_a = wetv_ff;
            mul_b = MW'(wgt_ff);
         end
         default: begin
            mul_a = '0;
         end
      endcase
   end

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      shape_in = shape_ff;
      step_in = step_ff;
      depth_in = depth_ff;
      swing_in = swing_ff;
      base_in = base_ff;
      wet_in = wet_ff;
      wi_in = wi_ff;
      fill_in = fill_ff;
      phase_in = phase_ff;
      ams_in = ams_ff;
      nint_in = nint_ff;
      nsh_in = nsh_ff;
      nlev_in = nlev_ff;
      dry_l_in = dry_l_ff;
      dry_r_in = dry_r_ff;
      wgt_in = wgt_ff;
      amv_in = amv_ff;
      pmv_in = pmv_ff;
      gain_in = gain_ff;
      wrap_in = wrap_ff;
      rp_in = rp_ff;
      nval_in = nval_ff;
      rd_ok_in = rd_ok_ff;
      mem_a_in = mem_a_ff;
      mem_b_in = mem_b_ff;
      acc_in = acc_ff;
      wetv_in = wetv_ff;
      ch_in = ch_ff;
      res_l_in = res_l_ff;
      res_r_in = res_r_ff;
      rsp_l_in = rsp_l_ff;
      rsp_r_in = rsp_r_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_port.ready;
      ram_we = 1'b0;
      ram_raddr = a_idx;

      // register writes
      if (csr_we) begin
         unique case (csr_index)
            rlam_pkg::CSR_WAVE_SHAPE: shape_in = csr_wdata[1:0];
            rlam_pkg::CSR_PHASE_STEP: step_in = csr_wdata;
            rlam_pkg::CSR_AM_DEPTH:   depth_in = csr_wdata[15:0];
            rlam_pkg::CSR_PM_SWING:   swing_in = csr_wdata[19:0];
            rlam_pkg::CSR_BASE_DELAY: base_in = csr_wdata[19:0];
            rlam_pkg::CSR_WET_MIX:    wet_in = csr_wdata[16:0];
            default: begin
               shape_in = shape_ff;
            end
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               dry_l_in = req_port.left_in;
               dry_r_in = req_port.right_in;
               wgt_in = (wet_ff > rlam_pkg::WET_FULL) ? rlam_pkg::WET_FULL : wet_ff;
               state_in = S_WRITE;
            end
         end
         // record the dry word; low mix passes it straight through
         S_WRITE: begin
            ram_we = 1'b1;
            if (fill_ff != FULL_FILL) fill_in = fill_ff + 1'b1;
            if (wgt_ff < rlam_pkg::BYPASS_LIMIT) begin
               res_l_in = dry_l_ff;
               res_r_in = dry_r_ff;
               state_in = S_OUT;
            end else begin
               state_in = S_SHAPE;
            end
         end
         // am value of the shape, pm product issued
         S_SHAPE: begin
            unique case (shape_ff)
               rlam_pkg::SHAPE_SAW: begin
                  amv_in = ONE_L - LW'(phase_ff[31:9]);
               end
               rlam_pkg::SHAPE_SQUARE: begin
                  if (!phase_ff[31]) begin
                     amv_in = ONE_L;
                     pmv_in = LW'(phase_ff[31:8]) - ONE_L;
                  end else begin
                     amv_in = -ONE_L;
                     pmv_in = (ONE_L * 3) - LW'(phase_ff[31:8]);
                  end
               end
               rlam_pkg::SHAPE_TRIANGLE: begin
                  if (phase_ff < 32'h4000_0000)
                     amv_in = LW'(phase_ff[31:8]);
                  else if (phase_ff < 32'hC000_0000)
                     amv_in = ONE_L - LW'(24'((phase_ff - 32'h4000_0000) >> 8));
                  else
                     amv_in = LW'(24'((phase_ff - 32'hC000_0000) >> 8)) - ONE_L;
               end
               default: begin
                  amv_in = noise_amv;
               end
            endcase
            state_in = S_PMV;
         end
         // pm value from the product
         S_PMV: begin
            unique case (shape_ff)
               rlam_pkg::SHAPE_SAW: begin
                  pmv_in = ONE_L - LW'(prod >>> 39);
               end
               rlam_pkg::SHAPE_TRIANGLE: begin
                  if (phase_ff[31] == phase_ff[30])
                     pmv_in = -(LW'(cos_base) + LW'(prod >>> 30));
                  else
                     pmv_in = LW'(cos_base) + LW'(prod >>> 30);
               end
               rlam_pkg::SHAPE_NOISE: begin
                  nint_in = nint_ff + LW'(prod >>> 16);
                  pmv_in = nint_ff + LW'(prod >>> 16);
               end
               default: begin
                  pmv_in = pmv_ff;
               end
            endcase
            state_in = S_AMS;
         end
         // am smoother, phase advance, lfsr step on wrap
         S_AMS: begin
            ams_in = ams_ff + LW'(prod >>> 16);
            phase_in = phase_sum[31:0];
            wrap_in = phase_sum[32];
            if (phase_sum[32]) nsh_in = {nsh_ff[0] ^ nsh_ff[3], nsh_ff[16:1]};
            state_in = S_NORM;
         end
         S_NORM: begin
            state_in = S_GAIN;
         end
         S_GAIN: begin
            gain_in = gain_w[PW-1] ? '0 : gain_w[22:0];
            state_in = S_DLY;
         end
         // read pointer behind the write point
         S_DLY: begin
            rp_in = RPW'($signed({1'b0, wi_ff, 8'b0}))
                  - (RPW'($signed({1'b0, base_ff})) + RPW'(prod >>> 22));
            state_in = wrap_ff ? S_NQ : S_WRAP;
         end
         S_NQ: begin
            nval_in = {nm, 16'b0} + 26'd500;
            state_in = S_NM;
         end
         S_NM: begin
            state_in = S_NL;
         end
         S_NL: begin
            nlev_in = $signed(prod[51:36] - 16'd32768);
            state_in = S_WRAP;
         end
         // bring the pointer into the store, one modulus a cycle
         S_WRAP: begin
            if (rp_ff[RPW-1])
               rp_in = rp_ff + MODM;
            else if (rp_ff >= MODM)
               rp_in = rp_ff - MODM;
            else
               state_in = S_RDA;
         end
         S_RDA: begin
            ram_raddr = a_idx;
            rd_ok_in = FW'(a_idx) < fill_ff;
            state_in = S_RDB;
         end
         S_RDB: begin
            ram_raddr = b_idx;
            mem_a_in = rd_ok_ff ? ram_q : '0;
            rd_ok_in = FW'(b_idx) < fill_ff;
            state_in = S_LATB;
         end
         S_LATB: begin
            mem_b_in = rd_ok_ff ? ram_q : '0;
            ch_in = 1'b0;
            state_in = S_M1;
         end
         // per channel: interpolate, apply gain, mix
         S_M1: begin
            state_in = S_M2;
         end
         S_M2: begin
            acc_in = prod;
            state_in = S_M3;
         end
         S_M3: begin
            wetv_in = MW'(sum_w >>> 8);
            state_in = S_M4;
         end
         S_M4: begin
            state_in = S_M5;
         end
         S_M5: begin
            wetv_in = MW'(prod >>> 22);
            state_in = S_M6;
         end
         S_M6: begin
            acc_in = prod;
            state_in = S_M7;
         end
         S_M7: begin
            if (ch_ff) begin
               res_r_in = mix_sat;
               state_in = S_OUT;
            end else begin
               res_l_in = mix_sat;
               ch_in = 1'b1;
               state_in = S_M1;
            end
         end
         // hand the word to the output register once it is free
         S_OUT: begin
            if (rsp_take) begin
               rsp_l_in = res_l_ff;
               rsp_r_in = res_r_ff;
               rsp_valid_in = 1'b1;
               wi_in = (wi_ff == LAST_IDX) ? '0 : wi_ff + 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         shape_ff <= '0;
         step_ff <= '0;
         depth_ff <= '0;
         swing_ff <= '0;
         base_ff <= rlam_pkg::BASE_DELAY_RESET;
         wet_ff <= '0;
         wi_ff <= '0;
         fill_ff <= '0;
         phase_ff <= '0;
         ams_ff <= '0;
         nint_ff <= '0;
         nsh_ff <= 17'd1;
         nlev_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         shape_ff <= shape_in;
         step_ff <= step_in;
         depth_ff <= depth_in;
         swing_ff <= swing_in;
         base_ff <= base_in;
         wet_ff <= wet_in;
         wi_ff <= wi_in;
         fill_ff <= fill_in;
         phase_ff <= phase_in;
         ams_ff <= ams_in;
         nint_ff <= nint_in;
         nsh_ff <= nsh_in;
         nlev_ff <= nlev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dry_l_ff <= dry_l_in;
      dry_r_ff <= dry_r_in;
      wgt_ff <= wgt_in;
      amv_ff <= amv_in;
      pmv_ff <= pmv_in;
      gain_ff <= gain_in;
      wrap_ff <= wrap_in;
      rp_ff <= rp_in;
      nval_ff <= nval_in;
      rd_ok_ff <= rd_ok_in;
      mem_a_ff <= mem_a_in;
      mem_b_ff <= mem_b_in;
      acc_ff <= acc_in;
      wetv_ff <= wetv_in;
      ch_ff <= ch_in;
      res_l_ff <= res_l_in;
      res_r_ff <= res_r_in;
      rsp_l_ff <= rsp_l_in;
      rsp_r_ff <= rsp_r_in;
   end

   assign req_port.ready = (state_ff == S_IDLE);
   assign rsp_port.valid = rsp_valid_ff;
   assign rsp_port.left_out = rsp_l_ff;
   assign rsp_port.right_out = rsp_r_ff;

`ifndef SYNTH
   a_accept_writes: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff == S_WRITE)
      else $error("accepted word not recorded next cycle");

   a_ptr_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RDA |-> (!rp_ff[RPW-1] && rp_ff < MODM))
      else $error("read pointer outside the store");

   a_out_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && rsp_take) |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("result word not presented");

   a_fill_tracks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && fill_ff != FULL_FILL) |-> FW'(wi_ff) == fill_ff)
      else $error("fill count out of step with write point");
`endif

endmodule

/* hw/rtl/rlam_ram.sv */
`timescale 1ns / 1ps

module rlam_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/rlam_mul.sv */
`timescale 1ns / 1ps

module rlam_mul (
   input  logic                            clock,
   input  logic signed [rlam_pkg::MW-1:0]  op_a,
   input  logic signed [rlam_pkg::MW-1:0]  op_b,
   output logic signed [rlam_pkg::PW-1:0]  prod
);

   logic signed [rlam_pkg::PW-1:0] prod_ff;

   // shared signed multiplier, product registered
   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
   end

   assign prod = prod_ff;

endmodule

/* hw/rtl/rlam_cos_lut.sv */
`timescale 1ns / 1ps

module rlam_cos_lut (
   input  logic [rlam_pkg::COS_LOG:0]      idx,
   output logic [rlam_pkg::CW-1:0]         base,
   output logic signed [rlam_pkg::CW:0]    slope
);

   logic [rlam_pkg::CW-1:0] tab [rlam_pkg::COS_N+1];
   logic [rlam_pkg::CW-1:0] hi;

   // quarter wave of cosine, filled at elaboration
   for (genvar g = 0; g <= rlam_pkg::COS_N; g++) begin : g_tab
      assign tab[g] = rlam_pkg::cos_point(g);
   end

   // table point and difference to the next point, flat past the last one
   always_comb begin
      if (idx >= (rlam_pkg::COS_LOG + 1)'(rlam_pkg::COS_N)) begin
         base = tab[rlam_pkg::COS_N];
         hi = tab[rlam_pkg::COS_N];
      end else begin
         base = tab[idx];
         hi = tab[idx + 1'b1];
      end
      slope = $signed({1'b0, hi}) - $signed({1'b0, base});
   end

endmodule
